@@ hw/rtl/rre_pkg.sv @@
// Shared types and constants for the rectangle raster engine.
`timescale 1ns / 1ps
`default_nettype none

package rre_pkg;

  // Coordinate width: covers the largest pixel coordinate and rectangle edge.
  localparam int CRD_W = 30;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_CHAR       = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } st_t;

  typedef struct packed {
    op_t                     op;
    logic                    fill;
    logic [7:0]              ch;
    logic [7:0]              rd_col;
    logic [7:0]              rd_row;
    logic                    rd_miss;
    logic signed [CRD_W-1:0] x_lo;
    logic signed [CRD_W-1:0] x_hi;
    logic signed [CRD_W-1:0] x_lo1;
    logic signed [CRD_W-1:0] x_hi1;
    logic signed [CRD_W-1:0] y_lo;
    logic signed [CRD_W-1:0] y_hi;
    logic signed [CRD_W-1:0] y_lo1;
    logic signed [CRD_W-1:0] y_hi1;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/rre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/rre_front.sv @@
// Command front end: accepts items, computes rectangle bounds and read range checks.
`timescale 1ns / 1ps
`default_nettype none

module rre_front import rre_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_operation,
  input  wire logic                                 in_fill_flag,
  input  wire logic signed [19:0]                   in_corner_x,
  input  wire logic signed [19:0]                   in_corner_y,
  input  wire logic signed [19:0]                   in_span_x,
  input  wire logic signed [19:0]                   in_span_y,
  input  wire logic [7:0]                           in_paint_char,
  input  wire logic [7:0]                           in_read_col,
  input  wire logic [7:0]                           in_read_row,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       cols,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]      rows,
  input  wire logic [7:0]                           bg_char,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output cmd_t                                      q_cmd
);

  localparam logic signed [CRD_W-1:0] ONE = CRD_W'(1) << FRAC_BITS;

  logic signed [CRD_W-1:0] x_lo, x_hi, y_lo, y_hi;

  assign in_ready = !q_full;

  assign x_lo = CRD_W'(in_corner_x);
  assign y_lo = CRD_W'(in_corner_y);
  assign x_hi = x_lo + CRD_W'(in_span_x);
  assign y_hi = y_lo + CRD_W'(in_span_y);

  // Drop the unused operation code.
  always_comb begin
    q_push = 1'b0;
    unique case (in_operation) inside
      OP_CLEAR, OP_DRAW, OP_READ: q_push = in_valid && !q_full;
      default:                    q_push = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd         = '0;
    q_cmd.op      = op_t'(in_operation);
    q_cmd.fill    = in_fill_flag;
    q_cmd.ch      = (op_t'(in_operation) == OP_CLEAR) ? bg_char : in_paint_char;
    q_cmd.rd_col  = in_read_col;
    q_cmd.rd_row  = in_read_row;
    q_cmd.rd_miss = (16'(in_read_col) >= 16'(cols)) || (16'(in_read_row) >= 16'(rows));
    q_cmd.x_lo    = x_lo;
    q_cmd.x_hi    = x_hi;
    q_cmd.x_lo1   = x_lo + ONE;
    q_cmd.x_hi1   = x_hi - ONE;
    q_cmd.y_lo    = y_lo;
    q_cmd.y_hi    = y_hi;
    q_cmd.y_lo1   = y_lo + ONE;
    q_cmd.y_hi1   = y_hi - ONE;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rre_fifo.sv @@
// Two-entry command queue between front end and raster back end.
`timescale 1ns / 1ps
`default_nettype none

module rre_fifo import rre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rre_back.sv @@
// Raster back end: scans the canvas for clear and draw, serves pixel reads.
`timescale 1ns / 1ps
`default_nettype none

module rre_back import rre_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]              cols,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]             rows,
  input  wire logic                                        q_valid,
  input  wire cmd_t                                        q_cmd,
  output logic                                             q_pop,
  output logic                                             ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          ram_waddr,
  output logic [7:0]                                       ram_wdata,
  output logic                                             ram_re,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          ram_raddr,
  input  wire logic [7:0]                                  ram_rdata,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [7:0]                                       out_pixel_char
);

  localparam int CXW = $clog2(MAX_WIDTH+1);
  localparam int RXW = $clog2(MAX_HEIGHT+1);
  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW  = $clog2(MAX_WIDTH*MAX_HEIGHT);

  st_t             state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [CIW-1:0]  col_r, col_nxt;
  logic [RIW-1:0]  row_r, row_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;

  logic                    last_col, last_row, canvas_empty, hit;
  logic signed [CRD_W-1:0] px, py;
  logic                    in_rect, on_edge;

  assign last_col     = ((CXW+1)'(col_r) + (CXW+1)'(1)) == (CXW+1)'(cols);
  assign last_row     = ((RXW+1)'(row_r) + (RXW+1)'(1)) == (RXW+1)'(rows);
  assign canvas_empty = (cols == '0) || (rows == '0);

  assign px = CRD_W'(col_r) << FRAC_BITS;
  assign py = CRD_W'(row_r) << FRAC_BITS;

  assign in_rect = (px >= cmd_r.x_lo) && (px <= cmd_r.x_hi) &&
                   (py >= cmd_r.y_lo) && (py <= cmd_r.y_hi);
  assign on_edge = (px < cmd_r.x_lo1) || (px > cmd_r.x_hi1) ||
                   (py < cmd_r.y_lo1) || (py > cmd_r.y_hi1);
  assign hit     = (cmd_r.op == OP_CLEAR) || (in_rect && (on_edge || cmd_r.fill));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op) inside
            OP_CLEAR, OP_DRAW: state_nxt = canvas_empty ? ST_IDLE : ST_SCAN;
            OP_READ:           state_nxt = q_cmd.rd_miss ? ST_IDLE : ST_READ;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_col && last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = base_r + AW'(col_r);
    ram_wdata = cmd_r.ch;
    ram_raddr = AW'(32'(q_cmd.rd_row) * MAX_WIDTH + 32'(q_cmd.rd_col));
    unique case (state_r)
      ST_IDLE: begin
        q_pop  = q_valid && ((q_cmd.op != OP_READ) || !out_valid_r);
        ram_re = q_pop && (q_cmd.op == OP_READ) && !q_cmd.rd_miss;
      end
      ST_SCAN: ram_we = hit;
      ST_READ: ram_we = 1'b0;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    if (q_pop) begin
      cmd_nxt  = q_cmd;
      col_nxt  = '0;
      row_nxt  = '0;
      base_nxt = '0;
      if ((q_cmd.op == OP_READ) && q_cmd.rd_miss) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = 8'd0;
      end
    end
    if (state_r == ST_SCAN) begin
      if (last_col) begin
        col_nxt  = '0;
        row_nxt  = row_r + RIW'(1);
        base_nxt = base_r + AW'(MAX_WIDTH);
      end else begin
        col_nxt = col_r + CIW'(1);
      end
    end
    if (state_r == ST_READ) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_char = out_char_r;

endmodule

`default_nettype wire

@@ hw/rtl/rectangle_raster_engine.sv @@
// Top level of the rectangle raster engine: configuration, front end, queue, back end and canvas RAM.
`timescale 1ns / 1ps
`default_nettype none

// Character canvas of MAX_WIDTH x MAX_HEIGHT bytes held in one RAM, pixel (c, r) at
// r*MAX_WIDTH + c. Clear and draw each first take the command from the queue, then
// scan one pixel per cycle through the single RAM write port; a zero-sized canvas
// skips the scan. A read passes through the registered RAM read, then the output
// register; a pixel outside the active canvas goes straight to the output register
// and returns 0. A two-entry command queue lets the input side keep taking items
// while a scan runs. The canvas is undefined after reset; clear it before reading.
module rectangle_raster_engine import rre_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_operation,
  input  wire logic                  in_fill_flag,
  input  wire logic signed [19:0]    in_corner_x,
  input  wire logic signed [19:0]    in_corner_y,
  input  wire logic signed [19:0]    in_span_x,
  input  wire logic signed [19:0]    in_span_y,
  input  wire logic [7:0]            in_paint_char,
  input  wire logic [7:0]            in_read_col,
  input  wire logic [7:0]            in_read_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_pixel_char
);

  localparam int CXW   = $clog2(MAX_WIDTH+1);
  localparam int RXW   = $clog2(MAX_HEIGHT+1);
  localparam int AW    = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int C_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int R_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  logic [CXW-1:0] cols_r, cols_nxt;
  logic [RXW-1:0] rows_r, rows_nxt;
  logic [7:0]     bg_char_r, bg_char_nxt;

  logic          q_full, q_push, q_pop, q_valid;
  cmd_t          push_cmd, head_cmd;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    bg_char_nxt = bg_char_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:
          cols_nxt = (32'(cfg_data) > MAX_WIDTH) ? CXW'(MAX_WIDTH) : CXW'(cfg_data);
        REG_CANVAS_HEIGHT:
          rows_nxt = (32'(cfg_data) > MAX_HEIGHT) ? RXW'(MAX_HEIGHT) : RXW'(cfg_data);
        REG_BG_CHAR:
          bg_char_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= CXW'(C_RST);
      rows_r    <= RXW'(R_RST);
      bg_char_r <= 8'd32;
    end else begin
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
      bg_char_r <= bg_char_nxt;
    end
  end

  rre_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_fill_flag  (in_fill_flag),
    .in_corner_x   (in_corner_x),
    .in_corner_y   (in_corner_y),
    .in_span_x     (in_span_x),
    .in_span_y     (in_span_y),
    .in_paint_char (in_paint_char),
    .in_read_col   (in_read_col),
    .in_read_row   (in_read_row),
    .cols          (cols_r),
    .rows          (rows_r),
    .bg_char       (bg_char_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  rre_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  rre_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cols           (cols_r),
    .rows           (rows_r),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_char (out_pixel_char)
  );

  rre_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH*MAX_HEIGHT)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("canvas read issued during a scan write");

  assert property (@(posedge clk) disable iff (!rst_n) ram_re |-> ##2 out_valid)
    else $error("canvas read did not reach the output register");

  assert property (@(posedge clk) disable iff (!rst_n) ram_re |-> !out_valid)
    else $error("canvas read issued while a result is still pending");

endmodule

`default_nettype wire

@@ tb/sv/rectangle_raster_engine_tb.sv @@
// Self-checking testbench for the rectangle raster engine: directed and random canvas commands.
`timescale 1ns / 1ps

module rectangle_raster_engine_tb;
  import rre_pkg::*;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int FIX_ONE    = 1 << FRAC_BITS;

  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 700000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 9;

  typedef struct {
    logic [1:0]         operation;
    logic               fill_flag;
    logic signed [19:0] corner_x;
    logic signed [19:0] corner_y;
    logic signed [19:0] span_x;
    logic signed [19:0] span_y;
    logic [7:0]         paint_char;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } raster_cmd_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_operation   = '0;
  logic                  in_fill_flag   = 1'b0;
  logic signed [19:0]    in_corner_x    = '0;
  logic signed [19:0]    in_corner_y    = '0;
  logic signed [19:0]    in_span_x      = '0;
  logic signed [19:0]    in_span_y      = '0;
  logic [7:0]            in_paint_char  = '0;
  logic [7:0]            in_read_col    = '0;
  logic [7:0]            in_read_row    = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [7:0]            out_pixel_char;

  raster_cmd_t cmd_queue[$];
  raster_cmd_t cur_cmd;
  logic [7:0]  expected_pixels[$];
  logic [7:0]  canvas_model [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [8:0]  model_width  = 9'd256;
  logic [8:0]  model_height = 9'd256;
  logic [7:0]  model_bg     = 8'd32;

  bit         holding     = 1'b0;
  int         send_gap    = 0;
  int         recv_gap    = 0;
  int         idle_odds   = 4;
  int         idle_cycles = 0;
  int         fail_count  = 0;
  logic [7:0] want_char;

  always #5 clk = ~clk;

  rectangle_raster_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_fill_flag   (in_fill_flag),
    .in_corner_x    (in_corner_x),
    .in_corner_y    (in_corner_y),
    .in_span_x      (in_span_x),
    .in_span_y      (in_span_y),
    .in_paint_char  (in_paint_char),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_char (out_pixel_char)
  );

  function automatic int active_cols();
    return (model_width > MAX_WIDTH) ? MAX_WIDTH : int'(model_width);
  endfunction

  function automatic int active_rows();
    return (model_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(model_height);
  endfunction

  function automatic void update_canvas_model(input raster_cmd_t cmd);
    int     cols;
    int     rows;
    longint lo_x;
    longint hi_x;
    longint lo_y;
    longint hi_y;
    longint px;
    longint py;
    longint one;
    bit     covered;
    bit     near_rim;
    cols = active_cols();
    rows = active_rows();
    one  = longint'(FIX_ONE);
    case (cmd.operation)
      OP_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            canvas_model[r*MAX_WIDTH + c] = model_bg;
      end
      OP_DRAW: begin
        lo_x = longint'(cmd.corner_x);
        lo_y = longint'(cmd.corner_y);
        hi_x = lo_x + longint'(cmd.span_x);
        hi_y = lo_y + longint'(cmd.span_y);
        for (int r = 0; r < rows; r++) begin
          py = longint'(r) * one;
          for (int c = 0; c < cols; c++) begin
            px = longint'(c) * one;
            covered  = px >= lo_x && px <= hi_x && py >= lo_y && py <= hi_y;
            near_rim = (px - lo_x < one) || (hi_x - px < one) ||
                       (py - lo_y < one) || (hi_y - py < one);
            if (covered && (near_rim || cmd.fill_flag))
              canvas_model[r*MAX_WIDTH + c] = cmd.paint_char;
          end
        end
      end
      OP_READ: begin
        if (cmd.read_col < cols && cmd.read_row < rows)
          expected_pixels.push_back(canvas_model[int'(cmd.read_row)*MAX_WIDTH + cmd.read_col]);
        else
          expected_pixels.push_back(8'h00);
      end
      default: ;
    endcase
  endfunction

  function automatic raster_cmd_t random_cmd();
    raster_cmd_t cmd;
    cmd.operation  = 2'($urandom());
    cmd.fill_flag  = 1'($urandom());
    cmd.corner_x   = 20'($urandom());
    cmd.corner_y   = 20'($urandom());
    cmd.span_x     = 20'($urandom());
    cmd.span_y     = 20'($urandom());
    cmd.paint_char = 8'($urandom());
    cmd.read_col   = 8'($urandom());
    cmd.read_row   = 8'($urandom());
    return cmd;
  endfunction

  function automatic raster_cmd_t clear_cmd();
    raster_cmd_t cmd;
    cmd = random_cmd();
    cmd.operation = OP_CLEAR;
    return cmd;
  endfunction

  function automatic raster_cmd_t draw_cmd(input logic fill, input int cx, input int cy,
                                           input int sx, input int sy, input logic [7:0] ch);
    raster_cmd_t cmd;
    cmd = random_cmd();
    cmd.operation  = OP_DRAW;
    cmd.fill_flag  = fill;
    cmd.corner_x   = 20'(cx);
    cmd.corner_y   = 20'(cy);
    cmd.span_x     = 20'(sx);
    cmd.span_y     = 20'(sy);
    cmd.paint_char = ch;
    return cmd;
  endfunction

  function automatic raster_cmd_t read_cmd(input int col, input int row);
    raster_cmd_t cmd;
    cmd = random_cmd();
    cmd.operation = OP_READ;
    cmd.read_col  = 8'(col);
    cmd.read_row  = 8'(row);
    return cmd;
  endfunction

  task automatic push_random_item();
    raster_cmd_t cmd;
    int          span_c;
    int          span_r;
    int          pick;
    cmd    = random_cmd();
    span_c = (active_cols() == 0) ? 1 : active_cols();
    span_r = (active_rows() == 0) ? 1 : active_rows();
    pick   = $urandom_range(0, 19);
    if (pick < 2) begin
      cmd.operation = OP_CLEAR;
    end else if (pick < 10) begin
      cmd.operation = OP_DRAW;
      if (pick < 8) begin
        cmd.corner_x = 20'(int'($urandom_range(0, (span_c + 6) * FIX_ONE)) - 3 * FIX_ONE);
        cmd.corner_y = 20'(int'($urandom_range(0, (span_r + 6) * FIX_ONE)) - 3 * FIX_ONE);
        cmd.span_x   = 20'(int'($urandom_range(0, (span_c + 6) * FIX_ONE)) - 2 * FIX_ONE);
        cmd.span_y   = 20'(int'($urandom_range(0, (span_r + 6) * FIX_ONE)) - 2 * FIX_ONE);
      end
    end else if (pick < 19) begin
      cmd.operation = OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        cmd.read_col = 8'($urandom_range(0, span_c));
        cmd.read_row = 8'($urandom_range(0, span_r));
      end
    end else begin
      cmd.operation = OP_UNUSED;
    end
    cmd_queue.push_back(cmd);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CANVAS_WIDTH:  model_width  = val;
      REG_CANVAS_HEIGHT: model_height = val;
      REG_BG_CHAR:       model_bg     = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || holding || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  task automatic finish_phase();
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: present queued commands, account each transfer in the canvas model.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        update_canvas_model(cur_cmd);
        holding = 1'b0;
      end
      if (!holding && cmd_queue.size() != 0) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 8);
        end else begin
          cur_cmd = cmd_queue.pop_front();
          holding = 1'b1;
          in_operation  <= cur_cmd.operation;
          in_fill_flag  <= cur_cmd.fill_flag;
          in_corner_x   <= cur_cmd.corner_x;
          in_corner_y   <= cur_cmd.corner_y;
          in_span_x     <= cur_cmd.span_x;
          in_span_y     <= cur_cmd.span_y;
          in_paint_char <= cur_cmd.paint_char;
          in_read_col   <= cur_cmd.read_col;
          in_read_row   <= cur_cmd.read_row;
        end
      end
      in_valid <= holding;
    end
  end

  // Monitor: compare each result transfer with the oldest expected pixel.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel_char expected none, actual %0d", $time, out_pixel_char);
          fail_count++;
        end else begin
          want_char = expected_pixels.pop_front();
          if (out_pixel_char !== want_char) begin
            $display("%0t: pixel_char expected %0d, actual %0d", $time, want_char,
                     out_pixel_char);
            fail_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        recv_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int k;
    int w;
    int h;
    int sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full canvas at reset settings: clear everything first, then a fractional rectangle.
    cmd_queue.push_back(clear_cmd());
    cmd_queue.push_back(draw_cmd(1'b1, 64128, 64320, 1216, 896, 8'h52));
    cmd_queue.push_back(read_cmd(255, 255));
    cmd_queue.push_back(read_cmd(250, 251));
    cmd_queue.push_back(read_cmd(0, 0));
    finish_phase();

    write_reg(REG_CANVAS_WIDTH, 9'd16);
    write_reg(REG_CANVAS_HEIGHT, 9'd12);
    write_reg(REG_BG_CHAR, 9'd255);
    cmd_queue.push_back(clear_cmd());
    cmd_queue.push_back(draw_cmd(1'b0, 640, 256, 2304, 1728, 8'h00));
    cmd_queue.push_back(draw_cmd(1'b1, -524288, -524288, 524287, 524287, 8'h11));
    cmd_queue.push_back(draw_cmd(1'b1, 524287, 524287, 524287, 524287, 8'h22));
    cmd_queue.push_back(draw_cmd(1'b1, 0, 0, -524288, -256, 8'h33));
    cmd_queue.push_back(draw_cmd(1'b1, -384, -64, 1280, 768, 8'hA5));
    cmd_queue.push_back(random_cmd());
    cmd_queue[$].operation = OP_UNUSED;
    cmd_queue.push_back(read_cmd(3, 2));
    cmd_queue.push_back(read_cmd(6, 4));
    cmd_queue.push_back(read_cmd(0, 0));
    cmd_queue.push_back(read_cmd(16, 0));
    cmd_queue.push_back(read_cmd(15, 11));
    finish_phase();

    write_reg(REG_CANVAS_WIDTH, 9'd0);
    cmd_queue.push_back(clear_cmd());
    cmd_queue.push_back(draw_cmd(1'b1, 0, 0, 2560, 2560, 8'h44));
    cmd_queue.push_back(read_cmd(0, 0));
    finish_phase();

    write_reg(REG_CANVAS_WIDTH, 9'd511);
    write_reg(REG_CANVAS_HEIGHT, 9'd1);
    write_reg(REG_BG_CHAR, 9'h15A);
    write_reg(REG_UNUSED, 9'h1FF);
    cmd_queue.push_back(clear_cmd());
    cmd_queue.push_back(draw_cmd(1'b1, 25600, -128, 39872, 128, 8'h01));
    cmd_queue.push_back(read_cmd(255, 0));
    cmd_queue.push_back(read_cmd(99, 0));
    finish_phase();

    for (phase = 0; phase <= RANDOM_PHASES; phase++) begin
      sel = $urandom_range(0, 3);
      idle_odds = (phase == RANDOM_PHASES || sel == 0) ? 0 : (1 << sel);
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        w = $urandom_range(257, 511);
        h = $urandom_range(0, 2);
      end else if (sel == 1) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(257, 511);
      end else begin
        w = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 24);
        h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 24);
      end
      write_reg(REG_CANVAS_WIDTH, 9'(w));
      write_reg(REG_CANVAS_HEIGHT, 9'(h));
      write_reg(REG_BG_CHAR, 9'($urandom()));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, 9'($urandom()));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        push_random_item();
        if (phase % 3 == 1 && k == PHASE_ITEMS / 2)
          wait_idle();
      end
      cmd_queue.push_back(read_cmd($urandom_range(0, 255), $urandom_range(0, 255)));
      finish_phase();
    end

    foreach (expected_pixels[i]) begin
      $display("%0t: pixel_char expected %0d, actual none", $time, expected_pixels[i]);
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
